// ===== src/fmc_pkg.sv =====
// Package for the map cache clock replacement block: sizes, codes and payload types.
// No dependencies; used by every module in src.
package fmc_pkg;
    localparam int ENTRIES   = 16;
    localparam int LOCK_BITS = 8;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [LOCK_BITS-1:0] LOCK_MAX = '1;
    localparam logic [3:0] CLOCK_RESET = 4'd3;

    localparam logic [2:0] MODE_LOCK   = 3'd0;
    localparam logic [2:0] MODE_UNLOCK = 3'd1;
    localparam logic [2:0] MODE_SETD   = 3'd2;
    localparam logic [2:0] MODE_CLRD   = 3'd3;
    localparam logic [2:0] MODE_GETD   = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_NO_VICTIM = 2'd2;
    localparam logic [1:0] ST_LOCK_SAT  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] group;
    } req_t;

    typedef struct packed {
        logic [7:0]  slot;
        logic        hit;
        logic        found;
        logic [15:0] group_out;
        logic [1:0]  status;
    } resp_t;

    // Operation handed along the row of cells, one cell per cycle.
    typedef enum logic [3:0] {
        OP_NONE  = 4'b0001,
        OP_MATCH = 4'b0010,
        OP_SWEEP = 4'b0100,
        OP_GETD  = 4'b1000
    } op_t;

    // Token passed from cell to cell.
    typedef struct packed {
        op_t             op;
        logic [15:0]     group;
        logic [IDX_W-1:0] target;
        logic            done;
        logic            any_cand;
        logic            hit;
        logic [15:0]     tag;
    } tok_t;

    // Write command broadcast to one cell.
    typedef struct packed {
        logic            fill;
        logic            reload;
        logic [2:0]      mode;
        logic [IDX_W-1:0] target;
        logic [15:0]     group;
        logic [3:0]      reload_val;
        logic            clr_dirty;
    } wcmd_t;

    typedef struct packed {
        logic            valid;
        logic            dirty;
        logic            cand;
        logic            lock_zero;
        logic            lock_max;
    } cst_t;
endpackage

// ===== src/fmc_cell.sv =====
// One table entry of the map cache with its share of the match, sweep and dirty search.
// Depends on fmc_pkg.
module fmc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [fmc_pkg::IDX_W-1:0] idx,
    input  logic               active,
    input  fmc_pkg::tok_t      tok_in,
    output fmc_pkg::tok_t      tok_out,
    input  fmc_pkg::wcmd_t     wcmd,
    output fmc_pkg::cst_t      cst
);
    import fmc_pkg::*;

    logic                 valid_reg, dirty_reg;
    logic [LOCK_BITS-1:0] locks_reg;
    logic [3:0]           clock_reg;
    logic [15:0]          tag_reg;
    logic                 sel;
    logic                 cand;

    assign sel  = (wcmd.target == idx);
    assign cand = !valid_reg || (!dirty_reg && locks_reg == '0);
    assign cst  = '{valid: valid_reg, dirty: dirty_reg, cand: cand,
                    lock_zero: (locks_reg == '0), lock_max: (locks_reg == LOCK_MAX)};

    // Token processing when the token sits at this cell.
    always_comb
    begin
        tok_out = tok_in;
        if (active && !tok_in.done)
        begin
            unique case (tok_in.op)
                OP_MATCH:
                begin
                    tok_out.any_cand = tok_in.any_cand | cand;
                    if (valid_reg && tag_reg == tok_in.group)
                    begin
                        tok_out.done   = 1'b1;
                        tok_out.hit    = 1'b1;
                        tok_out.target = idx;
                    end
                end
                OP_SWEEP:
                    if (!valid_reg || (cand && clock_reg == 4'd0))
                    begin
                        tok_out.done   = 1'b1;
                        tok_out.target = idx;
                    end
                OP_GETD:
                    if (valid_reg && dirty_reg && locks_reg == '0)
                    begin
                        tok_out.done   = 1'b1;
                        tok_out.target = idx;
                        tok_out.tag    = tag_reg;
                    end
                default: ;
            endcase
        end
    end

    // Entry state; the tag is payload and needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            locks_reg <= '0;
            clock_reg <= '0;
        end
        else
        begin
            if (active && !tok_in.done && tok_in.op == OP_SWEEP && valid_reg && cand
                && clock_reg != 4'd0)
                clock_reg <= clock_reg - 4'd1;
            if (sel && wcmd.clr_dirty)
                dirty_reg <= 1'b0;
            if (sel && wcmd.reload)
            begin
                clock_reg <= wcmd.reload_val;
                if (wcmd.fill)
                    valid_reg <= 1'b1;
                case (wcmd.mode)
                    MODE_LOCK:
                        if (wcmd.fill)
                            locks_reg <= {{(LOCK_BITS-1){1'b0}}, 1'b1};
                        else if (locks_reg != LOCK_MAX)
                            locks_reg <= locks_reg + 1'b1;
                    MODE_UNLOCK:
                        if (wcmd.fill)
                            locks_reg <= '0;
                        else if (locks_reg != '0)
                            locks_reg <= locks_reg - 1'b1;
                    MODE_SETD:
                        if (wcmd.fill)
                            locks_reg <= '0;
                    default:
                        if (wcmd.fill)
                            locks_reg <= '0;
                endcase
                if (wcmd.mode == MODE_SETD)
                    dirty_reg <= 1'b1;
                else if (wcmd.fill || wcmd.mode == MODE_CLRD)
                    dirty_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wcmd.reload && wcmd.fill)
            tag_reg <= wcmd.group;
    end
endmodule

// ===== src/fmc_ctrl.sv =====
// Sequencer that walks the request token along the cell row and forms the response.
// Depends on fmc_pkg.
module fmc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  fmc_pkg::req_t      req,
    output logic               busy,
    input  logic [3:0]         clock_reload,
    output logic [fmc_pkg::IDX_W-1:0] pos,
    output fmc_pkg::tok_t      tok,
    input  fmc_pkg::tok_t      tok_ret,
    output fmc_pkg::wcmd_t     wcmd,
    input  fmc_pkg::cst_t      tgt_st,
    output logic               done,
    output fmc_pkg::resp_t     result
);
    import fmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_APPLY = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    tok_t             tok_reg, tok_next;
    logic [2:0]       mode_reg;
    logic [IDX_W-1:0] pos_reg, pos_next, ptr_reg;
    logic             sweep_go;
    resp_t            res_reg, res_next;
    logic             done_reg;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] p);
        nxt = (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign busy   = (state_reg != S_IDLE);
    assign pos    = pos_reg;
    assign tok    = tok_reg;
    assign done   = done_reg;
    assign result = res_reg;
    assign sweep_go = tok_ret.done;

    always_comb
    begin
        state_next = state_reg;
        tok_next   = tok_reg;
        pos_next   = pos_reg;
        res_next   = res_reg;
        wcmd       = '0;
        wcmd.target     = tok_reg.target;
        wcmd.mode       = mode_reg;
        wcmd.group      = tok_reg.group;
        wcmd.reload_val = clock_reload;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    res_next = '0;
                    tok_next = '0;
                    tok_next.group = req.group;
                    pos_next = '0;
                    if (req.mode == MODE_GETD)
                    begin
                        tok_next.op = OP_GETD;
                        state_next  = S_WALK;
                    end
                    else if (req.mode <= MODE_CLRD)
                    begin
                        tok_next.op = OP_MATCH;
                        state_next  = S_WALK;
                    end
                    else
                    begin
                        tok_next.op = OP_NONE;
                        state_next  = S_RESP;
                    end
                end
            S_WALK:
            begin
                tok_next = tok_ret;
                if (tok_reg.op == OP_SWEEP)
                    pos_next = nxt(pos_reg);
                else
                    pos_next = pos_reg + 1'b1;
                if (tok_ret.done || (tok_reg.op != OP_SWEEP && pos_reg == LAST))
                begin
                    if (tok_reg.op == OP_MATCH && !tok_ret.done)
                    begin
                        if (tok_ret.any_cand)
                        begin
                            tok_next.op   = OP_SWEEP;
                            tok_next.done = 1'b0;
                            pos_next      = nxt(ptr_reg);
                        end
                        else
                        begin
                            res_next.status = ST_NO_VICTIM;
                            state_next = S_RESP;
                        end
                    end
                    else if (tok_reg.op == OP_GETD)
                    begin
                        if (tok_ret.done)
                        begin
                            res_next.found     = 1'b1;
                            res_next.slot      = 8'(tok_ret.target);
                            res_next.group_out = tok_ret.tag;
                            state_next = S_APPLY;
                        end
                        else
                            state_next = S_RESP;
                    end
                    else
                        state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_RESP;
                if (tok_reg.op == OP_GETD)
                    wcmd.clr_dirty = 1'b1;
                else
                begin
                    wcmd.reload = 1'b1;
                    wcmd.fill   = !tok_reg.hit;
                    res_next.slot = 8'(tok_reg.target);
                    res_next.hit  = tok_reg.hit;
                    if (mode_reg == MODE_LOCK && tok_reg.hit && tgt_st.lock_max)
                        res_next.status = ST_LOCK_SAT;
                    else if (mode_reg == MODE_UNLOCK && (!tok_reg.hit || tgt_st.lock_zero))
                        res_next.status = ST_UNDERFLOW;
                end
            end
            S_RESP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tok_reg   <= '{op: OP_NONE, default: '0};
            pos_reg   <= '0;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
            mode_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tok_reg   <= tok_next;
            pos_reg   <= pos_next;
            done_reg  <= (state_reg == S_RESP);
            if (state_reg == S_IDLE && start)
                mode_reg <= req.mode;
            if (state_reg == S_WALK && tok_reg.op == OP_SWEEP && sweep_go)
                ptr_reg <= pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end
endmodule

// ===== src/ftl_map_cache_clock_policy.sv =====
// Top level of the map cache with clock replacement, lock counts and dirty marks.
// Depends on fmc_pkg, fmc_cell and fmc_ctrl.
//
// Usage: raise start with a request on req while busy is low; the request is
// taken at that edge and busy stays high until done rises with the response.
// The response appears on result for one cycle, marked by done; the receiver
// cannot stall it. A token moves one cell per cycle along the row of entries:
// a lookup walks up to ENTRIES cells, a miss then runs the clock sweep from
// the entry after the pointer, at most 16 turns of the row, and a hit or fill
// is then applied in the apply state. A get dirty walks the row the same way;
// unused modes go straight to the response without a walk.
// clock_wr with clock_wdata writes the reload count (reset 3); the user must
// write it only while idle, as the block does not enforce this.
// Reset empties the table and clears the sweep pointer at once.
module ftl_map_cache_clock_policy (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  fmc_pkg::req_t  req,
    output logic           busy,
    input  logic           clock_wr,
    input  logic [3:0]     clock_wdata,
    output logic           done,
    output fmc_pkg::resp_t result
);
    import fmc_pkg::*;

    logic [3:0]       reload_reg;
    logic [IDX_W-1:0] pos;
    tok_t             tok;
    tok_t             chain [ENTRIES+1];
    wcmd_t            wcmd;
    cst_t             cst [ENTRIES];
    cst_t             tgt_st;

    // Reload register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reload_reg <= CLOCK_RESET;
        else if (clock_wr)
            reload_reg <= clock_wdata;
    end

    assign chain[0] = tok;
    assign tgt_st   = cst[wcmd.target];

    // Row of cells; only the cell under the token acts on it.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        tok_t t_out;
        fmc_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (IDX_W'(i)),
            .active  (busy && pos == IDX_W'(i)),
            .tok_in  (chain[i]),
            .tok_out (t_out),
            .wcmd    (wcmd),
            .cst     (cst[i])
        );
        assign chain[i+1] = (pos == IDX_W'(i)) ? t_out : chain[i];
    end

    fmc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .clock_reload (reload_reg),
        .pos          (pos),
        .tok          (tok),
        .tok_ret      (chain[ENTRIES]),
        .wcmd         (wcmd),
        .tgt_st       (tgt_st),
        .done         (done),
        .result       (result)
    );
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the map cache with clock replacement, lock counts and dirty marks.
// Depends on fmc_pkg and ftl_map_cache_clock_policy; predicts every response in step with requests.
module tb;
    import fmc_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    req_t       req;
    logic       busy;
    logic       clock_wr;
    logic [3:0] clock_wdata;
    logic       done;
    resp_t      result;

    // Model state of the cache table.
    logic [15:0]          m_tag   [ENTRIES];
    logic                 m_valid [ENTRIES];
    logic                 m_dirty [ENTRIES];
    logic [LOCK_BITS-1:0] m_locks [ENTRIES];
    logic [3:0]           m_clock [ENTRIES];
    logic [7:0]           m_ptr;
    logic [3:0]           m_reload;

    // Pending requests and the responses they should produce.
    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    mismatches;
    int    cycles;
    bit    drive_done;
    int    gap;

    // Groups that were used recently, so that hits are common.
    logic [15:0] recent[$];

    localparam int LIMIT = 3000000;

    ftl_map_cache_clock_policy DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .clock_wr    (clock_wr),
        .clock_wdata (clock_wdata),
        .done        (done),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Clock sweep for a victim; returns ENTRIES when every entry is pinned.
    function automatic int sweep_victim();
        int  pos;
        bit  any;
        any = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (!m_valid[i] || (!m_dirty[i] && m_locks[i] == 0))
                any = 1;
        if (!any)
            return ENTRIES;
        pos = m_ptr % ENTRIES;
        for (int s = 0; s < 17 * ENTRIES; s++)
        begin
            pos = (pos + 1) % ENTRIES;
            if (!m_valid[pos])
                break;
            if (!m_dirty[pos] && m_locks[pos] == 0)
            begin
                if (m_clock[pos] == 0)
                    break;
                m_clock[pos] = m_clock[pos] - 4'd1;
            end
        end
        m_ptr = pos[7:0];
        return pos;
    endfunction

    // Applies one request to the model and returns the response it causes.
    function automatic resp_t apply_request(req_t r);
        resp_t o;
        int    e;
        o = '0;
        if (r.mode == MODE_GETD)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (m_valid[i] && m_dirty[i] && m_locks[i] == 0)
                begin
                    m_dirty[i]  = 1'b0;
                    o.slot      = i[7:0];
                    o.found     = 1'b1;
                    o.group_out = m_tag[i];
                    break;
                end
        end
        else if (r.mode <= MODE_CLRD)
        begin
            e = ENTRIES;
            for (int i = 0; i < ENTRIES; i++)
                if (m_valid[i] && m_tag[i] == r.group)
                begin
                    e = i;
                    break;
                end
            if (e < ENTRIES)
            begin
                o.hit      = 1'b1;
                m_clock[e] = m_reload;
            end
            else
            begin
                e = sweep_victim();
                if (e < ENTRIES)
                begin
                    m_valid[e] = 1'b1;
                    m_dirty[e] = 1'b0;
                    m_tag[e]   = r.group;
                    m_locks[e] = '0;
                    m_clock[e] = m_reload;
                end
            end
            if (e >= ENTRIES)
                o = '{default: '0, status: ST_NO_VICTIM};
            else
            begin
                o.slot = e[7:0];
                case (r.mode)
                    MODE_LOCK:
                        if (m_locks[e] == LOCK_MAX)
                            o.status = ST_LOCK_SAT;
                        else
                            m_locks[e] = m_locks[e] + 1'b1;
                    MODE_UNLOCK:
                        if (m_locks[e] == 0)
                            o.status = ST_UNDERFLOW;
                        else
                            m_locks[e] = m_locks[e] - 1'b1;
                    MODE_SETD:
                        m_dirty[e] = 1'b1;
                    default:
                        m_dirty[e] = 1'b0;
                endcase
            end
        end
        return o;
    endfunction

    // Short gaps mostly, now and then a long one.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        if (k < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Picks a group: mostly recent ones, sometimes extremes or fresh ones.
    function automatic logic [15:0] pick_group();
        int k;
        k = $urandom_range(0, 99);
        if (k < 65 && recent.size() > 0)
            return recent[$urandom_range(0, recent.size() - 1)];
        if (k < 70)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom());
    endfunction

    task automatic push_req(logic [2:0] mode, logic [15:0] group);
        req_t r;
        r.mode  = mode;
        r.group = group;
        pending_reqs.push_back(r);
        if (recent.size() >= 24)
            void'(recent.pop_front());
        recent.push_back(group);
    endtask

    // Waits until the driver is empty and every response has come.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || expected_resps.size() != 0)
            @(posedge clk);
        repeat (18 * ENTRIES + 10) @(posedge clk);
    endtask

    task automatic write_reload(logic [3:0] value);
        @(posedge clk);
        clock_wr    <= 1'b1;
        clock_wdata <= value;
        @(posedge clk);
        clock_wr    <= 1'b0;
        m_reload = value;
    endtask

    // Request driver: one request from the queue after a random gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_resps.push_back(apply_request(req));
                if (pending_reqs.size() != 0 && gap == 0)
                begin
                    req <= pending_reqs.pop_front();
                    gap = pick_gap();
                end
                else
                    start <= 1'b0;
            end
            else if (!start && pending_reqs.size() != 0)
            begin
                if (gap > 0)
                    gap--;
                else
                begin
                    start <= 1'b1;
                    req   <= pending_reqs.pop_front();
                    gap = pick_gap();
                end
            end
        end
    end

    // Response monitor and timeout.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && done)
        begin
            if (expected_resps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response %p", result);
            end
            else
            begin
                resp_t want;
                want = expected_resps.pop_front();
                if (result.slot !== want.slot || result.hit !== want.hit
                    || result.found !== want.found
                    || result.group_out !== want.group_out
                    || result.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        logic [15:0] g;
        int          k;
        cycles      = 0;
        mismatches  = 0;
        gap         = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        clock_wr    = 1'b0;
        clock_wdata = 4'd0;
        m_ptr       = '0;
        m_reload    = CLOCK_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            m_tag[i]   = '0;
            m_valid[i] = 1'b0;
            m_dirty[i] = 1'b0;
            m_locks[i] = '0;
            m_clock[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: each mode, extreme groups, underflow, get dirty with none.
        push_req(MODE_GETD, 16'h0000);
        push_req(MODE_UNLOCK, 16'h0000);
        push_req(MODE_LOCK, 16'hFFFF);
        push_req(MODE_LOCK, 16'hFFFF);
        push_req(MODE_UNLOCK, 16'hFFFF);
        push_req(MODE_SETD, 16'h0001);
        push_req(MODE_CLRD, 16'h0001);
        push_req(MODE_SETD, 16'hA5A5);
        push_req(MODE_GETD, 16'h5A5A);
        push_req(MODE_GETD, 16'hFFFF);
        push_req(3'd5, 16'h1234);
        push_req(3'd6, 16'hFFFF);
        push_req(3'd7, 16'h0000);
        wait_idle();

        // Pin every entry to provoke no victim.
        write_reload(4'd0);
        for (int i = 0; i < ENTRIES; i++)
            push_req((i % 2) ? MODE_SETD : MODE_LOCK, 16'h0100 + i[15:0]);
        push_req(MODE_LOCK, 16'h7777);
        push_req(MODE_GETD, 16'h0000);
        push_req(MODE_LOCK, 16'h7777);
        wait_idle();

        // Lock saturation on one group.
        write_reload(4'd15);
        for (int i = 0; i < 257; i++)
            pending_reqs.push_back('{mode: MODE_LOCK, group: 16'h0100});
        for (int i = 0; i < 256; i++)
            pending_reqs.push_back('{mode: MODE_UNLOCK, group: 16'h0100});
        wait_idle();

        // Random phases under different reload counts.
        for (int p = 0; p < 5; p++)
        begin
            write_reload((p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom()));
            for (int n = 0; n < 180; n++)
            begin
                k = $urandom_range(0, 99);
                g = pick_group();
                if (k < 28)
                    push_req(MODE_LOCK, g);
                else if (k < 55)
                    push_req(MODE_UNLOCK, g);
                else if (k < 72)
                    push_req(MODE_SETD, g);
                else if (k < 82)
                    push_req(MODE_CLRD, g);
                else if (k < 96)
                    push_req(MODE_GETD, 16'($urandom()));
                else
                    push_req(3'($urandom_range(5, 7)), 16'($urandom()));
            end
            // Clear out dirty marks now and then so the table does not stay pinned.
            for (int i = 0; i < 20; i++)
                push_req(MODE_GETD, 16'($urandom()));
            wait_idle();
        end

        if (mismatches == 0 && expected_resps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
